// File: hw/rtl/tprq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprq_pkg
// Shared types and codes of the timed priority release queue.
// ----------------------------------------------------------------------------
package tprq_pkg;

  typedef enum logic [1:0] {
    MODE_ENQ   = 2'd0,
    MODE_TAKE  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_ENQUEUED  = 3'd0,
    KIND_READY     = 3'd1,
    KIND_NONE      = 3'd2,
    KIND_CLEARED   = 3'd3,
    KIND_FULL      = 3'd4,
    KIND_SEQ_EXH   = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_SCAN,
    ST_EMIT,
    ST_OUT
  } state_e;

  localparam logic [31:0] SeqLimit = 32'hFFFF_FFFF;
  localparam logic [31:0] SeqFirst = 32'd1;

endpackage

// File: hw/rtl/timed_priority_release_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_priority_release_queue_core
// Table of pending commands released in order of tick, urgency, sequence.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_axis group (mode selects enqueue, take-ready or
//   clear). Results leave on m_axis; tlast marks the final result of a command.
//   Enqueue and clear do their work on acceptance, then the result sits in the
//   output register until taken; a new command is accepted only after that.
//   A take-ready request first marks ready entries, one slot a cycle, through
//   the registered read; an empty take answers with a none result when the
//   marking ends. Then for every released entry one shared key comparator
//   scans the table, one slot a cycle, and the winner is loaded into the
//   output register, waiting while an earlier result is still held there.
//   The table is one slot-per-cycle memory read port feeding the comparator.
//   s_axis_tready is high only when the block is idle with no result pending.
//   When m_axis_tready is low the result holds, and a further result waits.
//   Reset empties the table and sets the sequence counter to one.
// ----------------------------------------------------------------------------
module timed_priority_release_queue_core
  import tprq_pkg::*;
#(
  parameter int DEPTH        = 32,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mode[1:0], release_tick[33:2], urgency[65:34], payload[97:66], now_tick[129:98]
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // kind[2:0], sequence_res[34:3], item_release_tick[66:35], item_urgency[98:67],
  // item_payload[130:99], pending_count[136:131]
  output logic [143:0] m_axis_tdata,
  output logic         m_axis_tlast
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LastIdx = IW'(DEPTH - 1);

  // Input field split
  logic [1:0]  in_mode;
  logic [31:0] in_rel, in_urg, in_pay, in_now;
  assign in_mode = s_axis_tdata[1:0];
  assign in_rel  = s_axis_tdata[33:2];
  assign in_urg  = s_axis_tdata[65:34];
  assign in_pay  = s_axis_tdata[97:66];
  assign in_now  = s_axis_tdata[129:98];

  // Slot storage: valid bits in flops, fields in a memory
  logic [DEPTH-1:0] valid_q, valid_d, ready_q, ready_d;
  logic [PAYLOAD_BITS-1:0] mem_pay [DEPTH];
  logic [31:0] mem_seq [DEPTH];
  logic [31:0] mem_rel [DEPTH];
  logic [31:0] mem_urg [DEPTH];

  state_e      state_q, state_d;
  logic [IW-1:0] idx_q, idx_d, best_q, best_d;
  logic        have_q, have_d;
  logic [31:0] now_q, now_d;
  logic [31:0] nseq_q, nseq_d;
  logic [CW-1:0] cnt_q, cnt_d, nrdy_q, nrdy_d;
  logic [31:0] b_seq_q, b_seq_d, b_rel_q, b_rel_d, b_urg_q, b_urg_d;
  logic [PAYLOAD_BITS-1:0] b_pay_q, b_pay_d;

  // Registered read of the slot under the scan index
  logic [31:0] r_seq_q, r_rel_q, r_urg_q;
  logic [PAYLOAD_BITS-1:0] r_pay_q;
  logic [IW-1:0] r_idx_q;
  logic        r_vld_q;

  // Output register
  logic         ov_q, ov_d, ol_q, ol_d;
  logic [143:0] od_q, od_d;

  // Free slot and count
  logic [IW-1:0] free_idx;
  logic          free_ok;
  logic          wr_en;
  logic [IW-1:0] wr_idx;

  always_comb begin
    free_idx = '0;
    free_ok  = 1'b0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IW'(i);
        free_ok  = 1'b1;
      end
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_seq[wr_idx] <= nseq_q;
      mem_rel[wr_idx] <= in_rel;
      mem_urg[wr_idx] <= in_urg;
      mem_pay[wr_idx] <= in_pay[PAYLOAD_BITS-1:0];
    end
    r_seq_q <= mem_seq[idx_q];
    r_rel_q <= mem_rel[idx_q];
    r_urg_q <= mem_urg[idx_q];
    r_pay_q <= mem_pay[idx_q];
    r_idx_q <= idx_q;
  end

  // Shared key compare: read slot orders before current best
  logic lt;
  always_comb begin
    if (r_rel_q != b_rel_q) lt = r_rel_q < b_rel_q;
    else if (r_urg_q != b_urg_q) lt = $signed(r_urg_q) < $signed(b_urg_q);
    else lt = r_seq_q < b_seq_q;
  end

  function automatic logic [143:0] pack_res(kind_e k, logic [31:0] s, logic [31:0] r,
                                            logic [31:0] u, logic [31:0] p,
                                            logic [CW-1:0] c);
    pack_res = {7'd0, 6'(c), p, u, r, s, k};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      ready_q <= '0;
      nseq_q  <= SeqFirst;
      cnt_q   <= '0;
      nrdy_q  <= '0;
      idx_q   <= '0;
      have_q  <= 1'b0;
      ov_q    <= 1'b0;
      ol_q    <= 1'b0;
      r_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      ready_q <= ready_d;
      nseq_q  <= nseq_d;
      cnt_q   <= cnt_d;
      nrdy_q  <= nrdy_d;
      idx_q   <= idx_d;
      have_q  <= have_d;
      ov_q    <= ov_d;
      ol_q    <= ol_d;
      r_vld_q <= (state_d == ST_SCAN) || (state_d == ST_MARK);
    end
  end

  always_ff @(posedge clk_i) begin
    od_q    <= od_d;
    now_q   <= now_d;
    best_q  <= best_d;
    b_seq_q <= b_seq_d;
    b_rel_q <= b_rel_d;
    b_urg_q <= b_urg_d;
    b_pay_q <= b_pay_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = ol_q;

  // Sequencer
  always_comb begin
    logic acc;
    logic rd_now;
    acc     = s_axis_tvalid && s_axis_tready;
    rd_now  = 1'b0;
    state_d = state_q;
    valid_d = valid_q;
    ready_d = ready_q;
    nseq_d  = nseq_q;
    cnt_d   = cnt_q;
    nrdy_d  = nrdy_q;
    idx_d   = idx_q;
    have_d  = have_q;
    now_d   = now_q;
    best_d  = best_q;
    b_seq_d = b_seq_q;
    b_rel_d = b_rel_q;
    b_urg_d = b_urg_q;
    b_pay_d = b_pay_q;
    ov_d    = ov_q && !m_axis_tready;
    ol_d    = ol_q;
    od_d    = od_q;
    wr_en   = 1'b0;
    wr_idx  = free_idx;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          unique case (in_mode)
            MODE_ENQ: begin
              ov_d = 1'b1;
              ol_d = 1'b1;
              if (nseq_q == SeqLimit) begin
                od_d = pack_res(KIND_SEQ_EXH, '0, '0, '0, '0, cnt_q);
              end else if (!free_ok) begin
                od_d = pack_res(KIND_FULL, '0, '0, '0, '0, cnt_q);
              end else begin
                wr_en = 1'b1;
                valid_d[free_idx] = 1'b1;
                nseq_d = nseq_q + 32'd1;
                cnt_d  = cnt_q + CW'(1);
                od_d   = pack_res(KIND_ENQUEUED, nseq_q, '0, '0, '0, cnt_q + CW'(1));
              end
            end
            MODE_TAKE: begin
              now_d   = in_now;
              idx_d   = '0;
              nrdy_d  = '0;
              ready_d = '0;
              state_d = ST_MARK;
            end
            MODE_CLEAR: begin
              valid_d = '0;
              nseq_d  = SeqFirst;
              cnt_d   = '0;
              ov_d    = 1'b1;
              ol_d    = 1'b1;
              od_d    = pack_res(KIND_CLEARED, '0, '0, '0, '0, '0);
            end
            default: ;
          endcase
        end
      end
      ST_MARK: begin
        // one slot a cycle: read data arrives registered, in the cycle after its index
        rd_now = r_vld_q && (state_q == ST_MARK) && (idx_q != '0 || have_q);
        if (rd_now && valid_q[r_idx_q] && (r_rel_q <= now_q)) begin
          ready_d[r_idx_q] = 1'b1;
          valid_d[r_idx_q] = 1'b0;
          nrdy_d = nrdy_q + CW'(1);
          cnt_d  = cnt_q - CW'(1);
        end
        if (have_q && r_idx_q == LastIdx[IW-1:0]) begin
          have_d = 1'b0;
          if (nrdy_d == '0) begin
            state_d = ST_IDLE;
            ov_d = 1'b1;
            ol_d = 1'b1;
            od_d = pack_res(KIND_NONE, '0, '0, '0, '0, cnt_d);
          end else begin
            state_d = ST_SCAN;
            idx_d   = '0;
          end
        end else begin
          have_d = 1'b1;
          if (idx_q != LastIdx[IW-1:0]) idx_d = idx_q + IW'(1);
        end
      end
      ST_SCAN: begin
        // best-so-far selection, one slot a cycle
        if (have_q || idx_q != '0 || DEPTH == 1) begin
          if (ready_q[r_idx_q] && (!have_q || lt)) begin
            have_d  = 1'b1;
            best_d  = r_idx_q;
            b_seq_d = r_seq_q;
            b_rel_d = r_rel_q;
            b_urg_d = r_urg_q;
            b_pay_d = r_pay_q;
          end
        end
        if (r_vld_q && r_idx_q == LastIdx[IW-1:0] && idx_q == LastIdx[IW-1:0] &&
            (have_q || idx_q != '0 || DEPTH == 1)) begin
          state_d = ST_EMIT;
        end else if (idx_q != LastIdx[IW-1:0]) begin
          idx_d = idx_q + IW'(1);
        end
      end
      ST_EMIT: begin
        if (!ov_q || m_axis_tready) begin
          ready_d[best_q] = 1'b0;
          nrdy_d = nrdy_q - CW'(1);
          ov_d = 1'b1;
          ol_d = (nrdy_q == CW'(1));
          od_d = pack_res(KIND_READY, b_seq_q, b_rel_q, b_urg_q,
                          32'(b_pay_q), cnt_q);
          have_d = 1'b0;
          idx_d  = '0;
          state_d = (nrdy_q == CW'(1)) ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  // pending count never exceeds the table size
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(DEPTH))
    else $error("pending count overflow");
  // no input taken while a result waits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) ov_q |-> !s_axis_tready)
    else $error("accept with pending result");
  // ready and valid sets are disjoint
  a_dis: assert property (@(posedge clk_i) disable iff (!rst_ni) (ready_q & valid_q) == '0)
    else $error("slot both ready and valid");
`endif

endmodule
